// ===== hw/rtl/rar_pkg.sv =====
`default_nettype none
package rar_pkg;
    localparam int FIELD_BITS = 16;
    localparam int NUM_BITS   = 33;
    localparam int DEN_BITS   = 32;

    typedef enum logic {
        OP_MAKE = 1'b0,
        OP_ADD  = 1'b1
    } op_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rational_add_reduce.sv =====
`default_nettype none
// sequence: add first forms the cross products and the denominator product on the bit-serial
// multiplier; make and add then run the binary gcd loop (one step per cycle) and two
// bit-serial divisions sharing one divider; empty operands skip straight to the output state
// throughput: one item at a time, next item accepted once the result is taken
// reset: synchronous active-low aresetn clears the sequencer and valid flags
module rational_add_reduce
    import rar_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: num_a[15:0], den_a[31:16], num_b[47:32], den_b[63:48]
    input  wire logic [63:0] s_tdata,
    // tuser: operation
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: result_num[32:0], result_den[64:33], zero fill [71:65]
    output logic [71:0]      m_tdata,
    // tuser: result_empty
    output logic             m_tuser
);
    localparam int VB = VALUE_BITS;
    localparam int PW = 2 * VB;
    localparam int NW = PW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_GCD, S_DIVN, S_DIVD, S_OUT
    } state_t;

    state_t        state_reg;
    logic [VB-1:0] na_reg, da_reg, nb_reg, db_reg;
    logic [NW-1:0] n_reg, g_reg, rn_reg;
    logic [PW-1:0] d_reg;
    logic [NUM_BITS-1:0] on_reg;
    logic [DEN_BITS-1:0] od_reg;
    logic          empty_reg, mvalid_reg;

    logic          mul_start, gcd_start, div_start;
    logic [VB-1:0] mul_a, mul_b;
    logic          mul_done, gcd_done, div_done;
    logic [PW-1:0] mul_p;
    logic [NW-1:0] gcd_g, div_n, div_q;

    logic [VB-1:0] in_na, in_da, in_nb, in_db;
    assign in_na = s_tdata[VB-1:0];
    assign in_da = s_tdata[16+VB-1:16];
    assign in_nb = s_tdata[32+VB-1:32];
    assign in_db = s_tdata[48+VB-1:48];

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        mul_a = na_reg; mul_b = db_reg;
        case (state_reg)
            S_MUL2:  begin mul_a = da_reg; mul_b = nb_reg; end
            S_MUL3:  begin mul_a = da_reg; mul_b = db_reg; end
            default: begin mul_a = na_reg; mul_b = db_reg; end
        endcase
    end

    assign div_n = (state_reg == S_DIVD) ? NW'(d_reg) : n_reg;

    rar_mul #(.W(VB)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
    );
    rar_gcd #(.W(NW)) u_gcd (
        .aclk(aclk), .aresetn(aresetn), .start(gcd_start),
        .u(n_reg), .v(NW'(d_reg)), .done(gcd_done), .g(gcd_g)
    );
    rar_div #(.W(NW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .n(div_n), .d(g_reg), .done(div_done), .q(div_q)
    );

    logic started_reg;

    always_comb begin
        mul_start = 1'b0; gcd_start = 1'b0; div_start = 1'b0;
        if (!started_reg) begin
            case (state_reg)
                S_MUL1, S_MUL2, S_MUL3: mul_start = 1'b1;
                S_GCD:                  gcd_start = 1'b1;
                S_DIVN, S_DIVD:         div_start = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            mvalid_reg  <= 1'b0;
        end else begin
            started_reg <= 1'b1;
            case (state_reg)
                S_IDLE: begin
                    started_reg <= 1'b0;
                    if (s_tvalid) begin
                        na_reg <= in_na; da_reg <= in_da;
                        nb_reg <= in_nb; db_reg <= in_db;
                        n_reg  <= NW'(in_na);
                        d_reg  <= PW'(in_da);
                        if (in_da == '0 || (s_tuser == OP_ADD && in_db == '0)) begin
                            on_reg <= '0; od_reg <= '0; empty_reg <= 1'b1;
                            mvalid_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end else begin
                            empty_reg <= 1'b0;
                            state_reg <= (s_tuser == OP_ADD) ? S_MUL1 : S_GCD;
                        end
                    end
                end
                S_MUL1: if (mul_done) begin
                    n_reg <= NW'(mul_p); started_reg <= 1'b0; state_reg <= S_MUL2;
                end
                S_MUL2: if (mul_done) begin
                    n_reg <= n_reg + NW'(mul_p); started_reg <= 1'b0; state_reg <= S_MUL3;
                end
                S_MUL3: if (mul_done) begin
                    d_reg <= mul_p; started_reg <= 1'b0; state_reg <= S_GCD;
                end
                S_GCD: if (gcd_done) begin
                    g_reg <= gcd_g; started_reg <= 1'b0; state_reg <= S_DIVN;
                end
                S_DIVN: if (div_done) begin
                    rn_reg <= div_q; started_reg <= 1'b0; state_reg <= S_DIVD;
                end
                S_DIVD: if (div_done) begin
                    on_reg <= NUM_BITS'(rn_reg);
                    od_reg <= DEN_BITS'(div_q);
                    mvalid_reg <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_OUT: if (m_tready) begin
                    mvalid_reg <= 1'b0;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, od_reg, on_reg};
    assign m_tuser  = empty_reg;

    a_valid_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == S_OUT) else $error("valid outside output state");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (od_reg == '0 && on_reg == '0))
        else $error("empty result not zero");
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> od_reg != '0) else $error("zero denominator");
endmodule
`default_nettype wire

// ===== hw/rtl/rar_mul.sv =====
`default_nettype none
// shift-and-add multiplier, one multiplier bit per cycle
module rar_mul
    import rar_pkg::*;
#(
    parameter int W = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic                done,
    output logic [2*W-1:0]      p
);
    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg, acc_next;
    logic [2*W-1:0] mc_reg, mc_next;
    logic [W-1:0]   mp_reg, mp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            mc_next   = {{W{1'b0}}, a};
            mp_next   = b;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mp_reg[0]) acc_next = acc_reg + mc_reg;
            mc_next  = mc_reg << 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rar_gcd.sv =====
`default_nettype none
// binary gcd, one shift or subtract per cycle
module rar_gcd
    import rar_pkg::*;
#(
    parameter int W = 33
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] u,
    input  wire logic [W-1:0] v,
    output logic              done,
    output logic [W-1:0]      g
);
    localparam int SW = $clog2(W + 1);

    logic [W-1:0]  u_reg, u_next, v_reg, v_next;
    logic [SW-1:0] sh_reg, sh_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [W-1:0]  g_reg, g_next;

    always_comb begin
        u_next = u_reg; v_next = v_reg; sh_next = sh_reg;
        busy_next = busy_reg; done_next = 1'b0; g_next = g_reg;
        if (start) begin
            if (u == '0 || v == '0) begin
                g_next    = W'(1);
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                u_next = u; v_next = v; sh_next = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (u_reg == v_reg) begin
                g_next    = u_reg << sh_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!u_reg[0] && !v_reg[0]) begin
                u_next = u_reg >> 1; v_next = v_reg >> 1; sh_next = sh_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_next = u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_next = v_reg >> 1;
            end else if (u_reg > v_reg) begin
                u_next = (u_reg - v_reg) >> 1;
            end else begin
                v_next = (v_reg - u_reg) >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        u_reg  <= u_next;
        v_reg  <= v_next;
        sh_reg <= sh_next;
        g_reg  <= g_next;
    end

    assign done = done_reg;
    assign g    = g_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rar_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module rar_div
    import rar_pkg::*;
#(
    parameter int W = 33
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] n,
    input  wire logic [W-1:0] d,
    output logic              done,
    output logic [W-1:0]      q
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next, d_reg, d_next;
    logic [W:0]    r_reg, r_next, trial;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        q_next = q_reg; d_next = d_reg; r_next = r_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
        if (start) begin
            q_next = n; d_next = d; r_next = '0; cnt_next = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[W-1:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule
`default_nettype wire
